[rtl/cwlse_pkg.sv]
package cwlse_pkg;

    localparam int MAX_LEDS_DEF  = 64;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;
    localparam int BITS_PER_LED  = 24;

    localparam logic [7:0] ONE_CODE_RST  = 8'hF0;
    localparam logic [7:0] ZERO_CODE_RST = 8'h80;
    localparam logic [6:0] LED_COUNT_RST = 7'd8;

    localparam logic [7:0] SEG_GREEN_BLUE = 8'd85;
    localparam logic [7:0] SEG_BLUE_RED   = 8'd170;
    localparam logic [7:0] WHEEL_TOP      = 8'd255;
    localparam logic [4:0] LAST_BIT       = 5'(BITS_PER_LED - 1);

    typedef enum logic [1:0]
    {
        IDX_ONE_CODE  = 2'd0,
        IDX_ZERO_CODE = 2'd1,
        IDX_LED_COUNT = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        CH_GREEN = 2'd0,
        CH_RED   = 2'd1,
        CH_BLUE  = 2'd2
    } channel_t;

    function automatic logic [7:0] channel_value(input logic [7:0] pos, input logic [1:0] ch);
        logic [7:0] q;
        logic [7:0] q3;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] v;
        q  = 8'd0;
        if (pos < SEG_GREEN_BLUE)
        begin
            q = pos;
        end
        else if (pos < SEG_BLUE_RED)
        begin
            q = pos - SEG_GREEN_BLUE;
        end
        else
        begin
            q = pos - SEG_BLUE_RED;
        end
        q3 = q + {q[6:0], 1'b0};
        if (pos < SEG_GREEN_BLUE)
        begin
            r = WHEEL_TOP - q3;
            g = q3;
            b = 8'd0;
        end
        else if (pos < SEG_BLUE_RED)
        begin
            r = 8'd0;
            g = WHEEL_TOP - q3;
            b = q3;
        end
        else
        begin
            r = q3;
            g = 8'd0;
            b = WHEEL_TOP - q3;
        end
        case (ch)
            CH_GREEN: v = g;
            CH_RED:   v = r;
            default:  v = b;
        endcase
        return v;
    endfunction

endpackage

[rtl/color_wheel_led_strip_encoder.sv]
// Colour-wheel LED strip encoder.
// Item channel (item_valid/item_ready, byte_request): a beat with byte_request
// high asks for the next serial byte of the frame; a beat with it low is an
// idle beat that gives nothing and changes nothing.
// Result channel (result_valid/result_ready): serial_byte is the one code or
// the zero code for the current colour bit (green, red, blue, MSB first);
// last_of_led marks the 24th byte of an LED, last_of_frame the final byte of
// the frame, after which the wheel position steps and reverses at the ends.
// result_valid rises in the cycle after the item beat. Throughput: one byte
// per cycle unless stalled, set by the single result register after the ramp.
// item_ready stays high while the result register is empty or being taken,
// so a stalled receiver holds the result and holds off further items.
// Reset clears the position, sweep direction and counters and loads the
// default codes (0xF0, 0x80) and an LED count of 8; no result is pending.
// Registers (APB, 4-byte stride): 0x0 one_code, 0x4 zero_code, 0x8 led_count.
module color_wheel_led_strip_encoder #(
    parameter int MAX_LEDS = cwlse_pkg::MAX_LEDS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cwlse_pkg::ADDR_W-1:0]  paddr,
    input  logic [cwlse_pkg::DATA_W-1:0]  pwdata,
    output logic [cwlse_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          byte_request,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [7:0]                    serial_byte,
    output logic                          last_of_led,
    output logic                          last_of_frame
);

    localparam int LIW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int LCW  = $clog2(MAX_LEDS + 1);
    localparam int CMPW = ((LCW > 7) ? LCW : 7) + 1;

    logic [7:0]     one_code_reg;
    logic [7:0]     zero_code_reg;
    logic [6:0]     led_count_reg;
    logic [7:0]     wheel_position_reg;
    logic           sweep_up_reg;
    logic [LIW-1:0] led_index_reg;
    logic [4:0]     bit_index_reg;
    logic           result_valid_reg;
    logic [7:0]     serial_byte_reg;
    logic           last_of_led_reg;
    logic           last_of_frame_reg;

    logic [7:0]     wheel_position_next;
    logic           sweep_up_next;
    logic [LIW-1:0] led_index_next;
    logic [4:0]     bit_index_next;
    logic           result_valid_next;
    logic [7:0]     serial_byte_next;

    logic            cfg_write;
    logic            fire;
    logic [CMPW-1:0] count_ext;
    logic [CMPW-1:0] eff_count;
    logic [CMPW-1:0] led_num;
    logic [7:0]      chan_val;
    logic            cur_bit;
    logic            led_end;
    logic            frame_end;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign item_ready = !result_valid_reg || result_ready;
    assign fire       = item_valid && item_ready && byte_request;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            cwlse_pkg::IDX_ONE_CODE:  prdata = cwlse_pkg::DATA_W'(one_code_reg);
            cwlse_pkg::IDX_ZERO_CODE: prdata = cwlse_pkg::DATA_W'(zero_code_reg);
            cwlse_pkg::IDX_LED_COUNT: prdata = cwlse_pkg::DATA_W'(led_count_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        count_ext = CMPW'(led_count_reg);
        if (count_ext == '0)
        begin
            eff_count = CMPW'(1);
        end
        else if (count_ext > CMPW'(MAX_LEDS))
        begin
            eff_count = CMPW'(MAX_LEDS);
        end
        else
        begin
            eff_count = count_ext;
        end
        led_num   = CMPW'(led_index_reg) + CMPW'(1);
        chan_val  = cwlse_pkg::channel_value(wheel_position_reg, bit_index_reg[4:3]);
        cur_bit   = chan_val[3'd7 - bit_index_reg[2:0]];
        led_end   = (bit_index_reg == cwlse_pkg::LAST_BIT);
        frame_end = led_end && (led_num >= eff_count);
        serial_byte_next = cur_bit ? one_code_reg : zero_code_reg;
    end

    always_comb
    begin
        wheel_position_next = wheel_position_reg;
        sweep_up_next       = sweep_up_reg;
        led_index_next      = led_index_reg;
        bit_index_next      = bit_index_reg;
        if (fire)
        begin
            if (!led_end)
            begin
                bit_index_next = bit_index_reg + 5'd1;
            end
            else
            begin
                bit_index_next = '0;
                if (!frame_end)
                begin
                    led_index_next = led_index_reg + LIW'(1);
                end
                else
                begin
                    led_index_next = '0;
                    if (sweep_up_reg)
                    begin
                        if (wheel_position_reg == cwlse_pkg::WHEEL_TOP)
                        begin
                            sweep_up_next = 1'b0;
                        end
                        else
                        begin
                            wheel_position_next = wheel_position_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        if (wheel_position_reg == 8'd0)
                        begin
                            sweep_up_next = 1'b1;
                        end
                        else
                        begin
                            wheel_position_next = wheel_position_reg - 8'd1;
                        end
                    end
                end
            end
        end
        if (fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_code_reg       <= cwlse_pkg::ONE_CODE_RST;
            zero_code_reg      <= cwlse_pkg::ZERO_CODE_RST;
            led_count_reg      <= cwlse_pkg::LED_COUNT_RST;
            wheel_position_reg <= '0;
            sweep_up_reg       <= 1'b0;
            led_index_reg      <= '0;
            bit_index_reg      <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[3:2])
                    cwlse_pkg::IDX_ONE_CODE:  one_code_reg  <= pwdata[7:0];
                    cwlse_pkg::IDX_ZERO_CODE: zero_code_reg <= pwdata[7:0];
                    cwlse_pkg::IDX_LED_COUNT: led_count_reg <= pwdata[6:0];
                    default:                  one_code_reg  <= one_code_reg;
                endcase
            end
            wheel_position_reg <= wheel_position_next;
            sweep_up_reg       <= sweep_up_next;
            led_index_reg      <= led_index_next;
            bit_index_reg      <= bit_index_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            serial_byte_reg   <= serial_byte_next;
            last_of_led_reg   <= led_end;
            last_of_frame_reg <= frame_end;
        end
    end

    assign result_valid  = result_valid_reg;
    assign serial_byte   = serial_byte_reg;
    assign last_of_led   = last_of_led_reg;
    assign last_of_frame = last_of_frame_reg;

endmodule

[rtl/cwlse_checker.sv]
module cwlse_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       byte_request,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] serial_byte,
    input logic       last_of_led,
    input logic       last_of_frame
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(serial_byte)
        && $stable(last_of_led) && $stable(last_of_frame))
        else $error("stalled result beat changed");

    a_frame_on_led: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !last_of_frame || last_of_led)
        else $error("frame end outside LED end");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready && byte_request))
        else $error("result beat without a request beat");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item channel blocked with no pending result");

endmodule

bind color_wheel_led_strip_encoder cwlse_checker u_cwlse_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .byte_request  (byte_request),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .serial_byte   (serial_byte),
    .last_of_led   (last_of_led),
    .last_of_frame (last_of_frame)
);
